// ===== design/mtn_pkg.sv =====
// Package for the media timestamp normaliser: beat layouts, register
// indexes, configuration and item structs shared by all design files.
// No dependencies.
`default_nettype none

package mtn_pkg;

  // Field widths
  localparam int unsigned NsW    = 63;
  localparam int unsigned DurW   = 30;
  localparam int unsigned CntW   = 32;
  localparam int unsigned ThrW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  // Stream beat widths
  localparam int unsigned InDataW  = 128;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 224;
  localparam int unsigned OutUserW = 5;

  // Constants
  localparam logic [DurW-1:0] DefaultDurNs = DurW'(33333333);
  localparam logic [ThrW-1:0] MinLateNs    = ThrW'(250000000);
  localparam logic [NsW-1:0]  NsMax        = {NsW{1'b1}};
  localparam logic [CntW-1:0] CntMax       = {CntW{1'b1}};

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_FORCE_SYNTH = 2'd0,
    REG_ARRIVAL     = 2'd1,
    REG_FRAME_DUR   = 2'd2,
    REG_LATE_THR    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic            force_synth;
    logic            arrival_mode;
    logic [DurW-1:0] frame_dur;
    logic [ThrW-1:0] late_thr;
  } cfg_t;

  typedef struct packed {
    logic [NsW-1:0] raw_pts;
    logic           raw_pts_valid;
    logic [NsW-1:0] arrival_ns;
    logic           frame_empty;
  } in_item_t;

  typedef struct packed {
    logic            accepted;
    logic [NsW-1:0]  out_pts;
    logic            duration_valid;
    logic [DurW-1:0] out_duration;
    logic            synthesized;
    logic            gap_closed;
    logic [NsW-1:0]  skipped_ns;
    logic            late_arrival;
    logic [CntW-1:0] gap_total;
    logic [CntW-1:0] late_total;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/media_timestamp_normalizer.sv =====
// Top level of the media timestamp normaliser: input register, stamping
// core and result register. Depends on mtn_pkg, mtn_cfg_regs, mtn_stamp_core.
//
//   Channel   Direction  Beat
//   s_axis    in         one frame event
//   m_axis    out        one stamped result per frame event
//   cfg       in         one register write (index, data)
//
// Items pass the input register, then the result register; one item is taken
// every cycle unless the result stalls. The limit is the 64-bit subtract/compare
// chain of the rebased path and the 32x30 index multiply, both between the
// input and result registers. Reset clears all timeline state and the registers
// return to their defaults. A stalled result is held in the result
// register while one more item waits in the input register.
`default_nettype none

module media_timestamp_normalizer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // raw_pts [62:0], arrival_ns [125:63], zero pad [127:126]
  input  wire logic [mtn_pkg::InDataW-1:0]   s_axis_tdata,
  // raw_pts_valid [0], frame_empty [1]
  input  wire logic [mtn_pkg::InUserW-1:0]   s_axis_tuser,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // out_pts [62:0], out_duration [92:63], skipped_ns [155:93],
  // gap_total [187:156], late_total [219:188], zero pad [223:220]
  output logic [mtn_pkg::OutDataW-1:0]       m_axis_tdata,
  // accepted [0], duration_valid [1], synthesized [2], gap_closed [3],
  // late_arrival [4]
  output logic [mtn_pkg::OutUserW-1:0]       m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mtn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [mtn_pkg::CfgDatW-1:0]   cfg_data_i
);
  import mtn_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t res_d, res_q;
  logic      res_valid_q;
  logic      advance;

  // Registers always accept a write
  assign cfg_ready_o = 1'b1;

  mtn_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move an item forward when the result register is free or draining
  assign advance       = in_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.raw_pts       <= s_axis_tdata[NsW-1:0];
      in_q.arrival_ns    <= s_axis_tdata[2*NsW-1:NsW];
      in_q.raw_pts_valid <= s_axis_tuser[0];
      in_q.frame_empty   <= s_axis_tuser[1];
    end
  end

  mtn_stamp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (in_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Pack the result beat
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.late_total, res_q.gap_total, res_q.skipped_ns,
                          res_q.out_duration, res_q.out_pts};
  assign m_axis_tuser  = {res_q.late_arrival, res_q.gap_closed, res_q.synthesized,
                          res_q.duration_valid, res_q.accepted};

endmodule

`default_nettype wire

// ===== design/mtn_cfg_regs.sv =====
// Configuration register file of the timestamp normaliser.
// Depends on mtn_pkg.
`default_nettype none

module mtn_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [mtn_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [mtn_pkg::CfgDatW-1:0] cfg_data_i,
  output mtn_pkg::cfg_t                   cfg_o
);
  import mtn_pkg::*;

  cfg_t cfg_q;

  // Write one register per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_synth  <= 1'b0;
      cfg_q.arrival_mode <= 1'b0;
      cfg_q.frame_dur    <= DefaultDurNs;
      cfg_q.late_thr     <= MinLateNs;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FORCE_SYNTH: cfg_q.force_synth  <= cfg_data_i[0];
        REG_ARRIVAL:     cfg_q.arrival_mode <= cfg_data_i[0];
        REG_FRAME_DUR:   cfg_q.frame_dur    <= cfg_data_i[DurW-1:0];
        REG_LATE_THR:    cfg_q.late_thr     <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/mtn_stamp_core.sv =====
// Timeline state and single-pass stamping logic: source tracking, mode
// selection, gap closing and late detection. Depends on mtn_pkg.
`default_nettype none

module mtn_stamp_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  mtn_pkg::cfg_t       cfg_i,
  input  wire logic           step_i,
  input  mtn_pkg::in_item_t   item_i,
  output mtn_pkg::out_item_t  res_o
);
  import mtn_pkg::*;

  logic            synth_q, synth_d;
  logic [NsW-1:0]  src_last_q, src_last_d;
  logic            src_valid_q, src_valid_d;
  logic [NsW-1:0]  base_q, base_d;
  logic            base_valid_q, base_valid_d;
  logic [NsW-1:0]  out_last_q, out_last_d;
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] index_q, index_d;
  logic [CntW-1:0] gap_cnt_q, gap_cnt_d;
  logic [NsW-1:0]  origin_q, origin_d;
  logic            origin_valid_q, origin_valid_d;
  logic [NsW-1:0]  arr_last_q, arr_last_d;
  logic            arr_valid_q, arr_valid_d;
  logic [CntW-1:0] late_cnt_q, late_cnt_d;

  logic [DurW-1:0] dur;
  logic [ThrW-1:0] thr;
  logic            synth_now;
  logic            stamp_bad;
  logic [NsW-1:0]  org;
  logic [NsW-1:0]  arr_pts;
  logic [NsW-1:0]  arr_out;
  logic [CntW+DurW-1:0] syn_prod;
  logic [NsW-1:0]  syn_pts;
  logic [NsW-1:0]  base_sel;
  logic [NsW-1:0]  reb_pts;
  logic [NsW:0]    expected;
  logic [NsW:0]    exp_slack;
  logic            gap;
  logic [NsW-1:0]  skipped;
  logic [NsW-1:0]  arr_delta;
  logic            late;
  logic            use_arr, use_syn;

  // Substitute defaults for out-of-range settings
  assign dur = (cfg_i.frame_dur == '0) ? DefaultDurNs : cfg_i.frame_dur;
  assign thr = (cfg_i.late_thr < MinLateNs) ? MinLateNs : cfg_i.late_thr;

  // Source tracking: fall back to index timing on a missing or non-rising stamp
  assign stamp_bad = !item_i.raw_pts_valid ||
                     (src_valid_q && (item_i.raw_pts <= src_last_q));
  assign synth_now = synth_q || cfg_i.force_synth || stamp_bad;

  // Arrival path: rebase to first arrival, force strictly rising output up to the ceiling
  assign org     = origin_valid_q ? origin_q : item_i.arrival_ns;
  assign arr_pts = (item_i.arrival_ns >= org) ? (item_i.arrival_ns - org) : '0;
  always_comb begin
    arr_out = arr_pts;
    if (out_valid_q && (arr_pts <= out_last_q)) begin
      arr_out = (out_last_q == NsMax) ? NsMax : (out_last_q + NsW'(1));
    end
  end

  // Synthesized path: index times frame period, full 62-bit product
  assign syn_prod = {{DurW{1'b0}}, index_q} * {{CntW{1'b0}}, dur};
  assign syn_pts  = NsW'(syn_prod);

  // Rebased path: track the lowest stamp, close wide forward gaps
  assign base_sel  = (!base_valid_q || (item_i.raw_pts < base_q)) ? item_i.raw_pts : base_q;
  assign reb_pts   = item_i.raw_pts - base_sel;
  assign expected  = {1'b0, out_last_q} + (NsW+1)'(dur);
  assign exp_slack = expected + (NsW+1)'(dur);
  assign gap       = out_valid_q && ({1'b0, reb_pts} > exp_slack);
  assign skipped   = reb_pts - expected[NsW-1:0];

  // Late arrival check
  assign arr_delta = item_i.arrival_ns - arr_last_q;
  assign late      = arr_valid_q && (item_i.arrival_ns >= arr_last_q) &&
                     (arr_delta >= NsW'(thr));

  assign use_arr = cfg_i.arrival_mode;
  assign use_syn = !cfg_i.arrival_mode && synth_now;

  // Next state and result
  always_comb begin
    synth_d        = synth_q;
    src_last_d     = src_last_q;
    src_valid_d    = src_valid_q;
    base_d         = base_q;
    base_valid_d   = base_valid_q;
    out_last_d     = out_last_q;
    out_valid_d    = out_valid_q;
    index_d        = index_q;
    gap_cnt_d      = gap_cnt_q;
    origin_d       = origin_q;
    origin_valid_d = origin_valid_q;
    arr_last_d     = arr_last_q;
    arr_valid_d    = arr_valid_q;
    late_cnt_d     = late_cnt_q;
    res_o          = '0;
    res_o.gap_total  = gap_cnt_q;
    res_o.late_total = late_cnt_q;

    if (!item_i.frame_empty) begin
      synth_d = synth_now;
      if (!synth_now) begin
        src_last_d  = item_i.raw_pts;
        src_valid_d = 1'b1;
      end

      if (use_arr) begin
        origin_d       = org;
        origin_valid_d = 1'b1;
        out_last_d     = arr_out;
        out_valid_d    = 1'b1;
        res_o.out_pts  = arr_out;
      end else if (use_syn) begin
        index_d              = index_q + CntW'(1);
        res_o.out_pts        = syn_pts;
        res_o.duration_valid = 1'b1;
        res_o.out_duration   = dur;
      end else begin
        base_valid_d = 1'b1;
        out_valid_d  = 1'b1;
        if (gap) begin
          base_d           = item_i.raw_pts - expected[NsW-1:0];
          out_last_d       = expected[NsW-1:0];
          gap_cnt_d        = (gap_cnt_q == CntMax) ? CntMax : gap_cnt_q + CntW'(1);
          res_o.out_pts    = expected[NsW-1:0];
          res_o.gap_closed = 1'b1;
          res_o.skipped_ns = skipped;
        end else begin
          base_d        = base_sel;
          out_last_d    = reb_pts;
          res_o.out_pts = reb_pts;
        end
      end

      if (late) begin
        late_cnt_d = (late_cnt_q == CntMax) ? CntMax : late_cnt_q + CntW'(1);
      end
      arr_last_d  = item_i.arrival_ns;
      arr_valid_d = 1'b1;

      res_o.accepted     = 1'b1;
      res_o.synthesized  = synth_now;
      res_o.late_arrival = late;
      res_o.gap_total    = gap_cnt_d;
      res_o.late_total   = late_cnt_d;
    end
  end

  // Advance state once per consumed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synth_q        <= 1'b0;
      src_last_q     <= '0;
      src_valid_q    <= 1'b0;
      base_q         <= '0;
      base_valid_q   <= 1'b0;
      out_last_q     <= '0;
      out_valid_q    <= 1'b0;
      index_q        <= '0;
      gap_cnt_q      <= '0;
      origin_q       <= '0;
      origin_valid_q <= 1'b0;
      arr_last_q     <= '0;
      arr_valid_q    <= 1'b0;
      late_cnt_q     <= '0;
    end else if (step_i) begin
      synth_q        <= synth_d;
      src_last_q     <= src_last_d;
      src_valid_q    <= src_valid_d;
      base_q         <= base_d;
      base_valid_q   <= base_valid_d;
      out_last_q     <= out_last_d;
      out_valid_q    <= out_valid_d;
      index_q        <= index_d;
      gap_cnt_q      <= gap_cnt_d;
      origin_q       <= origin_d;
      origin_valid_q <= origin_valid_d;
      arr_last_q     <= arr_last_d;
      arr_valid_q    <= arr_valid_d;
      late_cnt_q     <= late_cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mtn_checker.sv =====
// Port-level checks for the media timestamp normaliser, bound to the top.
// Depends on mtn_pkg and media_timestamp_normalizer.
`default_nettype none

module mtn_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic [mtn_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire logic [mtn_pkg::OutUserW-1:0]  m_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready
);
  import mtn_pkg::*;

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
  else $error("result beat changed while stalled");

  // No result straight out of reset
  assert property (@(posedge clk_i) $past(!rst_ni) |-> !m_axis_tvalid)
  else $error("result valid after reset");

  // Rejected frame carries no stamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tuser[4:1] == '0 && m_axis_tdata[155:0] == '0)
  else $error("empty frame carries stamp fields");

  // Duration only with index timing, skip only with a closed gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser[1] || m_axis_tdata[92:63] == '0) &&
      (m_axis_tuser[3] || m_axis_tdata[155:93] == '0) &&
      (!m_axis_tuser[1] || m_axis_tuser[2]))
  else $error("duration or skip field inconsistent with flags");

endmodule

bind media_timestamp_normalizer mtn_checker u_mtn_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for media_timestamp_normalizer: directed plan of frame
// events and register writes, then random streams checked against a local stamp predictor.
// Depends on mtn_pkg and the design files of media_timestamp_normalizer.
`timescale 1ns / 1ps

module tb_top;
  import mtn_pkg::*;

  localparam logic [63:0] NominalDur = 64'd33333333;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_reg_e    reg_idx;
    logic [31:0] wr_data;
    in_item_t    frame;
    bit          has_want;
    out_item_t   want;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDatW-1:0]  cfg_data_i    = '0;

  // Predictor copy of the registers
  logic            cfg_force   = 1'b0;
  logic            cfg_arrival = 1'b0;
  logic [DurW-1:0] cfg_dur     = DefaultDurNs;
  logic [ThrW-1:0] cfg_thr     = MinLateNs;

  // Predictor copy of the timeline state
  logic        synth_on      = 1'b0;
  logic [63:0] src_last      = '0;
  logic        src_last_ok   = 1'b0;
  logic [63:0] base          = '0;
  logic        base_ok       = 1'b0;
  logic [63:0] prev_out      = '0;
  logic        prev_out_ok   = 1'b0;
  logic [31:0] frame_idx     = '0;
  logic [31:0] gap_cnt       = '0;
  logic [63:0] arr_origin    = '0;
  logic        arr_origin_ok = 1'b0;
  logic [63:0] arr_prev      = '0;
  logic        arr_prev_ok   = 1'b0;
  logic [31:0] late_cnt      = '0;

  out_item_t   pending_stamps[$];
  plan_row_t   plan[$];
  int unsigned mismatches   = 0;
  int unsigned frames_sent  = 0;
  bit          steady_flow  = 1'b0;
  logic [63:0] raw_cursor   = '0;
  logic [63:0] arr_cursor   = '0;

  media_timestamp_normalizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] eff_dur();
    return (cfg_dur != '0) ? 64'(cfg_dur) : 64'(DefaultDurNs);
  endfunction

  function automatic logic [63:0] eff_thr();
    return (cfg_thr < MinLateNs) ? 64'(MinLateNs) : 64'(cfg_thr);
  endfunction

  // Stamp one frame event and advance the predicted timeline
  function automatic out_item_t stamp_frame(input in_item_t f);
    out_item_t   r;
    logic [63:0] raw, arr, dur, pts, expd, skip, delta;
    r    = '0;
    raw  = 64'(f.raw_pts);
    arr  = 64'(f.arrival_ns);
    dur  = eff_dur();
    skip = '0;
    if (f.frame_empty) begin
      r.gap_total  = gap_cnt;
      r.late_total = late_cnt;
      return r;
    end
    // source tracking runs in every mode
    if (cfg_force) synth_on = 1'b1;
    if (!synth_on) begin
      if (!f.raw_pts_valid || (src_last_ok && raw <= src_last)) begin
        synth_on = 1'b1;
      end else begin
        src_last    = raw;
        src_last_ok = 1'b1;
      end
    end
    if (cfg_arrival) begin
      if (!arr_origin_ok) begin
        arr_origin    = arr;
        arr_origin_ok = 1'b1;
      end
      pts = (arr >= arr_origin) ? arr - arr_origin : 64'd0;
      if (prev_out_ok && pts <= prev_out)
        pts = (prev_out >= 64'(NsMax)) ? 64'(NsMax) : prev_out + 64'd1;
      prev_out    = pts;
      prev_out_ok = 1'b1;
    end else if (synth_on) begin
      pts              = ({32'd0, frame_idx} * dur) & 64'(NsMax);
      r.duration_valid = 1'b1;
      r.out_duration   = dur[DurW-1:0];
      frame_idx        = frame_idx + 32'd1;
    end else begin
      if (!base_ok || raw < base) begin
        base    = raw;
        base_ok = 1'b1;
      end
      pts = raw - base;
      // close a forward gap wider than one frame of slack
      if (prev_out_ok) begin
        expd = prev_out + dur;
        if (pts > expd + dur) begin
          skip         = pts - expd;
          base         = base + skip;
          gap_cnt      = (gap_cnt == CntMax) ? CntMax : gap_cnt + 32'd1;
          r.gap_closed = 1'b1;
          pts          = expd;
        end
      end
      prev_out    = pts;
      prev_out_ok = 1'b1;
    end
    if (arr_prev_ok) begin
      delta = (arr >= arr_prev) ? arr - arr_prev : 64'd0;
      if (delta >= eff_thr()) begin
        r.late_arrival = 1'b1;
        late_cnt       = (late_cnt == CntMax) ? CntMax : late_cnt + 32'd1;
      end
    end
    arr_prev    = arr;
    arr_prev_ok = 1'b1;
    r.accepted    = 1'b1;
    r.out_pts     = pts[NsW-1:0];
    r.synthesized = synth_on;
    r.skipped_ns  = skip[NsW-1:0];
    r.gap_total   = gap_cnt;
    r.late_total  = late_cnt;
    return r;
  endfunction

  function automatic logic [62:0] rand63();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[62:0];
  endfunction

  function automatic in_item_t frame_of(input logic [63:0] raw, input logic vld,
                                        input logic [63:0] arr, input logic empty);
    in_item_t f;
    f.raw_pts       = raw[62:0];
    f.raw_pts_valid = vld;
    f.arrival_ns    = arr[62:0];
    f.frame_empty   = empty;
    return f;
  endfunction

  // Empty frame with random content; must leave the timeline alone
  function automatic in_item_t noise_frame();
    return frame_of(64'(rand63()), 1'($urandom_range(0, 1)), 64'(rand63()), 1'b1);
  endfunction

  // Advance arrival time: mostly small steps, some around the late threshold, some back
  function automatic logic [62:0] next_arrival();
    logic [63:0]  thr, back;
    int unsigned  pick;
    thr  = eff_thr();
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      arr_cursor = arr_cursor + thr - 64'd1;
    end else if (pick < 14) begin
      arr_cursor = arr_cursor + thr + 64'($urandom_range(0, 3));
    end else if (pick < 22) begin
      back       = 64'($urandom_range(1, 100_000_000));
      arr_cursor = (arr_cursor > back) ? arr_cursor - back : 64'd0;
    end else begin
      arr_cursor = arr_cursor + 64'($urandom_range(0, thr[32:1]));
    end
    return arr_cursor[62:0];
  endfunction

  task automatic add_frame(input in_item_t f);
    plan_row_t r;
    r.kind     = ROW_FRAME;
    r.reg_idx  = REG_FORCE_SYNTH;
    r.wr_data  = '0;
    r.frame    = f;
    r.has_want = 1'b0;
    r.want     = '0;
    plan.push_back(r);
  endtask

  task automatic add_checked(input in_item_t f, input out_item_t w);
    add_frame(f);
    plan[$].has_want = 1'b1;
    plan[$].want     = w;
  endtask

  task automatic add_write(input cfg_reg_e idx, input logic [31:0] data);
    plan_row_t r;
    r.kind     = ROW_WRITE;
    r.reg_idx  = idx;
    r.wr_data  = data;
    r.frame    = '0;
    r.has_want = 1'b0;
    r.want     = '0;
    plan.push_back(r);
  endtask

  // Offer one frame beat, sometimes after a random idle gap, and log its stamp on acceptance
  task automatic send_frame(input in_item_t f, input bit has_want, input out_item_t want);
    out_item_t stamp;
    if (!steady_flow && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 19);
    end
    s_axis_tdata  <= {2'b00, f.arrival_ns, f.raw_pts};
    s_axis_tuser  <= {f.frame_empty, f.raw_pts_valid};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    stamp = stamp_frame(f);
    pending_stamps.push_back(has_want ? want : stamp);
    frames_sent++;
  endtask

  // Drain the block, then write one register
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FORCE_SYNTH: cfg_force   = data[0];
      REG_ARRIVAL:     cfg_arrival = data[0];
      REG_FRAME_DUR:   cfg_dur     = data[DurW-1:0];
      REG_LATE_THR:    cfg_thr     = data;
      default: ;
    endcase
  endtask

  // Pick new register settings between random segments
  task automatic retune(input bit synth_phase);
    logic [31:0] d;
    case ($urandom_range(0, 5))
      0:       d = 32'd0;
      1:       d = 32'd1;
      2:       d = 32'd1_000_000_000;
      3:       d = $urandom;
      default: d = $urandom_range(1000, 40_000_000);
    endcase
    if ($urandom_range(0, 1) == 0) write_reg(REG_FRAME_DUR, d);
    case ($urandom_range(0, 3))
      0:       d = $urandom_range(0, 249_999_999);
      1:       d = 32'hFFFF_FFFF;
      default: d = $urandom_range(250_000_000, 400_000_000);
    endcase
    if ($urandom_range(0, 2) == 0) write_reg(REG_LATE_THR, d);
    d    = $urandom;
    d[0] = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 2) == 0) write_reg(REG_ARRIVAL, d);
    d = $urandom;
    if (!synth_phase) d[0] = 1'b0;
    if ($urandom_range(0, 3) == 0) write_reg(REG_FORCE_SYNTH, d);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Result side: random back-pressure and field-by-field checking of each beat
  always @(posedge clk_i) begin : result_monitor
    out_item_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted       = m_axis_tuser[0];
      got.duration_valid = m_axis_tuser[1];
      got.synthesized    = m_axis_tuser[2];
      got.gap_closed     = m_axis_tuser[3];
      got.late_arrival   = m_axis_tuser[4];
      got.out_pts        = m_axis_tdata[62:0];
      got.out_duration   = m_axis_tdata[92:63];
      got.skipped_ns     = m_axis_tdata[155:93];
      got.gap_total      = m_axis_tdata[187:156];
      got.late_total     = m_axis_tdata[219:188];
      if (pending_stamps.size() == 0) begin
        report_mismatch("result beat with no frame outstanding");
      end else begin
        want = pending_stamps.pop_front();
        check_field("accepted", 64'(got.accepted), 64'(want.accepted));
        check_field("out_pts", 64'(got.out_pts), 64'(want.out_pts));
        check_field("duration_valid", 64'(got.duration_valid), 64'(want.duration_valid));
        check_field("out_duration", 64'(got.out_duration), 64'(want.out_duration));
        check_field("synthesized", 64'(got.synthesized), 64'(want.synthesized));
        check_field("gap_closed", 64'(got.gap_closed), 64'(want.gap_closed));
        check_field("skipped_ns", 64'(got.skipped_ns), 64'(want.skipped_ns));
        check_field("late_arrival", 64'(got.late_arrival), 64'(want.late_arrival));
        check_field("gap_total", 64'(got.gap_total), 64'(want.gap_total));
        check_field("late_total", 64'(got.late_total), 64'(want.late_total));
      end
    end
    m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 19);
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] rc;
    out_item_t   w;
    in_item_t    f;
    logic [63:0] inc, dur;
    int unsigned pick, seg, n;

    // Directed plan: rebased path first, then arrival mode; the timeline stays unsynthesized
    add_checked(frame_of(64'(NsMax), 1'b1, 64'(NsMax), 1'b1), '0);
    add_write(REG_FORCE_SYNTH, 32'hFFFF_FFFE);
    w          = '0;
    w.accepted = 1'b1;
    rc         = 64'd1000;
    add_checked(frame_of(rc, 1'b1, 64'd0, 1'b0), w);
    rc = rc + NominalDur;
    add_frame(frame_of(rc, 1'b1, NominalDur, 1'b0));
    rc = rc + NominalDur + 64'd5;
    add_frame(frame_of(rc, 1'b1, 2 * NominalDur, 1'b0));
    // forward gap, then a late arrival right at the threshold, then arrival going back
    rc = rc + 10 * NominalDur;
    add_frame(frame_of(rc, 1'b1, 3 * NominalDur, 1'b0));
    rc = rc + NominalDur;
    add_frame(frame_of(rc, 1'b1, 3 * NominalDur + 64'd250_000_000, 1'b0));
    rc = rc + NominalDur;
    add_frame(frame_of(rc, 1'b1, NominalDur, 1'b0));
    // threshold below a quarter second is raised
    add_write(REG_LATE_THR, 32'd100);
    rc = rc + NominalDur;
    add_frame(frame_of(rc, 1'b1, NominalDur + 64'd249_999_999, 1'b0));
    add_write(REG_LATE_THR, 32'hFFFF_FFFF);
    rc = rc + NominalDur;
    add_frame(frame_of(rc, 1'b1, NominalDur + 64'd249_999_999 + 64'hFFFF_FFFF, 1'b0));
    // zero duration falls back to the nominal one; gap boundary either side
    add_write(REG_FRAME_DUR, 32'd0);
    rc = rc + 2 * NominalDur;
    add_frame(frame_of(rc, 1'b1, 64'd5_000_000_000, 1'b0));
    rc = rc + 2 * NominalDur + 64'd1;
    add_frame(frame_of(rc, 1'b1, 64'd5_000_000_001, 1'b0));
    add_write(REG_FRAME_DUR, 32'hFFFF_FFFF);
    rc = rc + 2 * 64'h3FFF_FFFF + 64'd1;
    add_frame(frame_of(rc, 1'b1, 64'd5_000_000_002, 1'b0));
    add_write(REG_FRAME_DUR, 32'd1);
    rc = rc + 64'd2;
    add_frame(frame_of(rc, 1'b1, 64'd5_000_000_003, 1'b0));
    rc = rc + 64'd3;
    add_frame(frame_of(rc, 1'b1, 64'd5_000_000_004, 1'b0));
    add_write(REG_FRAME_DUR, 32'd1_000_000_000);
    rc = rc + 64'd1_000_000_000;
    add_frame(frame_of(rc, 1'b1, 64'd5_000_000_005, 1'b0));
    // arrival mode: origin, arrival before origin, then climb to the ceiling and hold
    add_write(REG_ARRIVAL, 32'd1);
    rc = rc + NominalDur;
    add_frame(frame_of(rc, 1'b1, 64'd1, 1'b0));
    rc = rc + NominalDur;
    add_frame(frame_of(rc, 1'b1, 64'd0, 1'b0));
    repeat (3) begin
      rc = rc + NominalDur;
      add_frame(frame_of(rc, 1'b1, 64'(NsMax), 1'b0));
    end
    add_write(REG_ARRIVAL, 32'd0);
    add_write(REG_FRAME_DUR, 32'(NominalDur));
    rc = rc + NominalDur;
    add_frame(frame_of(rc, 1'b1, 64'd0, 1'b0));
    add_frame(frame_of(64'd0, 1'b0, 64'd0, 1'b1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].wr_data);
      end else begin
        send_frame(plan[i].frame, plan[i].has_want, plan[i].want);
      end
    end

    // Random rebased and arrival streams with strictly rising source stamps
    raw_cursor = rc;
    arr_cursor = '0;
    seg        = 0;
    while (frames_sent < 520) begin
      retune(1'b0);
      steady_flow = (seg == 5);
      n = $urandom_range(15, 50);
      repeat (n) begin
        if ($urandom_range(0, 99) < 8) begin
          f = noise_frame();
        end else begin
          dur  = eff_dur();
          pick = $urandom_range(0, 99);
          if (pick < 70)
            inc = dur - dur / 16 + 64'($urandom_range(0, 32'(dur / 8)));
          else if (pick < 85)
            inc = 2 * dur + 64'($urandom_range(0, 1));
          else
            inc = dur * 64'($urandom_range(3, 40));
          raw_cursor = raw_cursor + inc;
          f = frame_of(raw_cursor, 1'b1, 64'(next_arrival()), 1'b0);
        end
        send_frame(f, 1'b0, '0);
      end
      seg++;
    end
    steady_flow = 1'b0;

    // Enter the synthesized timeline by one of its three routes
    case ($urandom_range(0, 2))
      0: write_reg(REG_FORCE_SYNTH, 32'd1);
      1: send_frame(frame_of(64'(rand63()), 1'b0, 64'(next_arrival()), 1'b0), 1'b0, '0);
      default: send_frame(frame_of(raw_cursor - 64'($urandom_range(0, 1000)), 1'b1,
                                   64'(next_arrival()), 1'b0), 1'b0, '0);
    endcase

    // Random synthesized streams with arbitrary source stamps
    seg = 0;
    while (frames_sent < 850) begin
      retune(1'b1);
      if (seg == 2) write_reg(REG_FORCE_SYNTH, 32'd1);
      n = $urandom_range(15, 50);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          f = noise_frame();
        end else if (pick < 18) begin
          arr_cursor = 64'(rand63());
          f = frame_of(64'(rand63()), 1'($urandom_range(0, 1)), arr_cursor, 1'b0);
        end else begin
          f = frame_of(64'(rand63()), 1'($urandom_range(0, 1)), 64'(next_arrival()), 1'b0);
        end
        send_frame(f, 1'b0, '0);
      end
      seg++;
    end

    // Drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
